FILE: rtl/hlpd_pkg.sv
package hlpd_pkg;

    // Default header length in characters
    localparam int HEADER_CHARS_DEF = 4;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int TAG_W  = 16;
    localparam int LEN_W  = 16;
    localparam int DIG_W  = 4;

    // Packed stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = BYTE_W + TAG_W;
    localparam int M_TUSER_W = 2;

    // One result item
    typedef struct packed {
        logic [TAG_W-1:0]  stream_tag;
        logic              header_error;
        logic              empty_packet;
        logic              last_of_packet;
        logic [BYTE_W-1:0] out_byte;
    } t_result;

endpackage

FILE: rtl/hlpd_parse.sv
module hlpd_parse #(
    parameter int HEADER_CHARS = hlpd_pkg::HEADER_CHARS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [hlpd_pkg::BYTE_W-1:0]  i_byte,
    input  logic [hlpd_pkg::TAG_W-1:0]   i_stream_id,
    output logic                         o_res_valid,
    output hlpd_pkg::t_result            o_res
);
    import hlpd_pkg::*;

    localparam int CNT_W = (HEADER_CHARS > 1) ? $clog2(HEADER_CHARS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HEADER_CHARS - 1);

    logic              r_in_payload;
    logic [CNT_W-1:0]  r_digits;
    logic [LEN_W-1:0]  r_len_acc;
    logic [LEN_W-1:0]  r_remain;
    logic              r_bad_seen;

    logic              n_in_payload;
    logic [CNT_W-1:0]  n_digits;
    logic [LEN_W-1:0]  n_len_acc;
    logic [LEN_W-1:0]  n_remain;
    logic              n_bad_seen;

    logic [DIG_W-1:0]  digit;
    logic              digit_bad;
    logic [LEN_W-1:0]  acc_shift;
    logic              bad_any;
    logic [LEN_W-1:0]  remain_dec;

    // Decode one ASCII hex character; bad characters give zero
    always_comb begin
        digit     = '0;
        digit_bad = 1'b0;
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            digit = DIG_W'(i_byte - 8'h30);
        end else if (i_byte >= 8'h61 && i_byte <= 8'h66) begin
            digit = DIG_W'(i_byte - 8'h57);
        end else if (i_byte >= 8'h41 && i_byte <= 8'h46) begin
            digit = DIG_W'(i_byte - 8'h37);
        end else begin
            digit_bad = 1'b1;
        end
    end

    assign acc_shift  = {r_len_acc[LEN_W-DIG_W-1:0], digit};
    assign bad_any    = r_bad_seen | digit_bad;
    assign remain_dec = r_remain - LEN_W'(1);

    // Advance header and payload state for the accepted item
    always_comb begin
        n_in_payload = r_in_payload;
        n_digits     = r_digits;
        n_len_acc    = r_len_acc;
        n_remain     = r_remain;
        n_bad_seen   = r_bad_seen;
        o_res_valid  = 1'b0;
        o_res        = '{stream_tag: i_stream_id, header_error: 1'b0,
                         empty_packet: 1'b0, last_of_packet: 1'b0,
                         out_byte: i_byte};
        if (i_accept) begin
            if (r_in_payload) begin
                n_remain             = remain_dec;
                o_res_valid          = 1'b1;
                o_res.last_of_packet = (remain_dec == '0);
                if (remain_dec == '0) begin
                    n_in_payload = 1'b0;
                end
            end else if (r_digits != CNT_LAST) begin
                n_digits   = r_digits + CNT_W'(1);
                n_len_acc  = acc_shift;
                n_bad_seen = bad_any;
            end else begin
                // Header complete: start a new header either way
                n_digits   = '0;
                n_len_acc  = '0;
                n_bad_seen = 1'b0;
                if (bad_any || acc_shift == '0) begin
                    o_res_valid          = 1'b1;
                    o_res.out_byte       = '0;
                    o_res.last_of_packet = 1'b1;
                    o_res.empty_packet   = 1'b1;
                    o_res.header_error   = bad_any;
                end else begin
                    n_remain     = acc_shift;
                    n_in_payload = 1'b1;
                end
            end
        end
    end

    // Hold parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload <= 1'b0;
            r_digits     <= '0;
            r_len_acc    <= '0;
            r_remain     <= '0;
            r_bad_seen   <= 1'b0;
        end else begin
            r_in_payload <= n_in_payload;
            r_digits     <= n_digits;
            r_len_acc    <= n_len_acc;
            r_remain     <= n_remain;
            r_bad_seen   <= n_bad_seen;
        end
    end

endmodule

FILE: rtl/hlpd_out.sv
module hlpd_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  hlpd_pkg::t_result  i_res,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_ready,
    output hlpd_pkg::t_result  o_res
);
    import hlpd_pkg::*;

    logic    r_out_vld;
    t_result r_out;
    logic    r_skid_vld;
    t_result r_skid;
    logic    drain;

    assign drain   = !r_out_vld || i_ready;
    assign o_ready = !r_skid_vld;
    assign o_valid = r_out_vld;
    assign o_res   = r_out;

    // Control: refill the output register, park an item in the skid when stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (drain) begin
            r_out_vld  <= r_skid_vld || i_valid;
            r_skid_vld <= 1'b0;
        end else if (i_valid) begin
            r_skid_vld <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (drain) begin
            r_out <= r_skid_vld ? r_skid : i_res;
        end else if (i_valid) begin
            r_skid <= i_res;
        end
    end

endmodule

FILE: rtl/hex_length_prefixed_deframer.sv
// Output: a result item is registered in the output stage when the input item that
// causes it is accepted, or parked in the skid stage while the master side stalls.
// Throughput: one input item per cycle while the skid stage is empty; the output
// register and a one-item skid stage let input continue while a result waits to be taken.
// Reset: synchronous, active low; clears parser state, the stream identifier and
// both output stages.
module hex_length_prefixed_deframer #(
    parameter int HEADER_CHARS = hlpd_pkg::HEADER_CHARS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [hlpd_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // [7:0] in_byte
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [hlpd_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // [7:0] out_byte, [23:8] stream_tag
    output logic                            m_axis_tlast,  // last_of_packet
    output logic [hlpd_pkg::M_TUSER_W-1:0]  m_axis_tuser,  // [0] empty_packet, [1] header_error
    input  logic                            i_cfg_we,
    input  logic [hlpd_pkg::TAG_W-1:0]      i_cfg_wdata
);
    import hlpd_pkg::*;

    logic [TAG_W-1:0] r_stream_id;
    logic             accept;
    logic             res_valid;
    t_result          res;
    t_result          out_res;

    assign accept = s_axis_tvalid && s_axis_tready;

    // Hold the stream identifier
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_id <= '0;
        end else if (i_cfg_we) begin
            r_stream_id <= i_cfg_wdata;
        end
    end

    hlpd_parse #(
        .HEADER_CHARS (HEADER_CHARS)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (s_axis_tdata[BYTE_W-1:0]),
        .i_stream_id (r_stream_id),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    hlpd_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_res   (res),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    // Pack the result item
    assign m_axis_tdata = {out_res.stream_tag, out_res.out_byte};
    assign m_axis_tlast = out_res.last_of_packet;
    assign m_axis_tuser = {out_res.header_error, out_res.empty_packet};

endmodule

FILE: rtl/hlpd_checker.sv
module hlpd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [1:0]  m_axis_tuser
);

    // A stalled result item holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("stalled result item changed");

    // An empty packet is a single last item carrying a zero byte
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata[7:0] == 8'h00)
        else $error("empty packet not marked last or byte not zero");

    // A header error only comes with an empty packet
    a_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
        else $error("header error on a payload item");

    // Input stalls only while a result is pending
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

    // Nothing is offered just after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("output not idle after reset");

endmodule

bind hex_length_prefixed_deframer hlpd_checker u_hlpd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: verif/hex_length_prefixed_deframer_tb.sv
module hex_length_prefixed_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hlpd_pkg::*;

    localparam int          HDR_CHARS   = HEADER_CHARS_DEF;
    localparam logic [4:0]  NOT_HEX     = 5'd16;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          SETTLE      = 4;
    localparam int          IDLE_PCT    = 31;
    localparam int          MAX_REPORTS = 10;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;   // [7:0] in_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;        // [7:0] out_byte, [23:8] stream_tag
    logic                  m_axis_tlast;        // last_of_packet
    logic [M_TUSER_W-1:0]  m_axis_tuser;        // [0] empty_packet, [1] header_error
    logic                  i_cfg_we = 1'b0;
    logic [TAG_W-1:0]      i_cfg_wdata = '0;

    hex_length_prefixed_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Raw stream bytes waiting to be sent, and packet results still owed
    logic [BYTE_W-1:0] framed_q [$];
    t_result           deframed_q [$];

    // Own copy of the parser state and the stream identifier
    logic              in_payload = 1'b0;
    int                hdr_count = 0;
    logic [LEN_W-1:0]  len_acc = '0;
    logic [LEN_W-1:0]  remaining = '0;
    logic              bad_hex = 1'b0;
    logic [TAG_W-1:0]  tag_reg = '0;

    bit calm = 1'b0;
    int n_fail = 0;
    int n_driven = 0;
    int n_checked = 0;
    int n_empty = 0;
    int n_hdr_err = 0;
    int n_tags = 1;
    int cycle_count = 0;

    // Directed opening: empty packet, one and two byte packets with extreme payload,
    // then bad headers built from the characters either side of each hex range
    logic [BYTE_W-1:0] directed_bytes [27] = '{
        "0", "0", "0", "0",
        "0", "0", "0", "1", 8'hA5,
        "0", "0", "0", "2", 8'h00, 8'hFF,
        8'h47, "0", "0", "1",
        8'h00, 8'h2F, 8'h3A, 8'hFF,
        8'h40, 8'h60, 8'h67, "F"
    };

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h57);
        if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h37);
        return NOT_HEX;
    endfunction

    // Advance the parser by one accepted byte and queue any packet result it makes
    function automatic void deframe_byte(input logic [7:0] b);
        t_result    r;
        logic [4:0] nib;
        r = '0;
        r.stream_tag = tag_reg;
        if (in_payload) begin
            remaining = remaining - 1'b1;
            r.out_byte = b;
            r.last_of_packet = (remaining == '0);
            deframed_q.push_back(r);
            if (r.last_of_packet) in_payload = 1'b0;
            return;
        end
        nib = hex_nibble(b);
        if (nib == NOT_HEX) begin
            bad_hex = 1'b1;
            nib = 5'd0;
        end
        len_acc = {len_acc[LEN_W-DIG_W-1:0], nib[DIG_W-1:0]};
        if (hdr_count + 1 < HDR_CHARS) begin
            hdr_count++;
            return;
        end
        // header complete: a bad or zero length gives one empty packet
        if (bad_hex || len_acc == '0) begin
            r.last_of_packet = 1'b1;
            r.empty_packet = 1'b1;
            r.header_error = bad_hex;
            deframed_q.push_back(r);
        end else begin
            remaining = len_acc;
            in_payload = 1'b1;
        end
        hdr_count = 0;
        len_acc = '0;
        bad_hex = 1'b0;
    endfunction

    function automatic void note_failure(input string msg);
        n_fail++;
        if (n_fail <= MAX_REPORTS) $display("[%0t] %s", $time, msg);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return 8'h30 + nib;
        return ($urandom_range(1) != 0) ? 8'h37 + nib : 8'h57 + nib;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (hex_nibble(c) != NOT_HEX);
        return c;
    endfunction

    // Queue one frame; a broken frame gets one non-hex header character and no payload
    function automatic int queue_frame(input logic [LEN_W-1:0] len, input bit broken);
        int bad_pos;
        bad_pos = broken ? $urandom_range(HDR_CHARS - 1) : -1;
        for (int k = 0; k < HDR_CHARS; k++) begin
            if (k == bad_pos) framed_q.push_back(non_hex_byte());
            else framed_q.push_back(hex_char(len[LEN_W-1-DIG_W*k -: DIG_W]));
        end
        if (broken) return HDR_CHARS;
        for (int k = 0; k < int'(len); k++) framed_q.push_back(8'($urandom_range(255)));
        return HDR_CHARS + int'(len);
    endfunction

    task automatic write_stream_id(input logic [TAG_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tag_reg = v;
        n_tags++;
    endtask

    // Hold until every byte is taken and every result has come, then let the pipe settle
    task automatic wait_drained();
        do @(posedge i_clk);
        while (framed_q.size() != 0 || s_axis_tvalid || deframed_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Driver: predict on each accepted byte, then offer the next one or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                deframe_byte(s_axis_tdata);
                n_driven++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (framed_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= framed_q.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result against the oldest owed one, stall at random
    always @(posedge i_clk) begin : monitor_p
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.out_byte       = m_axis_tdata[BYTE_W-1:0];
                got.stream_tag     = m_axis_tdata[BYTE_W +: TAG_W];
                got.last_of_packet = m_axis_tlast;
                got.empty_packet   = m_axis_tuser[0];
                got.header_error   = m_axis_tuser[1];
                if (deframed_q.size() == 0) begin
                    note_failure($sformatf("unexpected result byte=%02h tag=%04h",
                                           got.out_byte, got.stream_tag));
                end else begin
                    want = deframed_q.pop_front();
                    n_checked++;
                    if (want.empty_packet) n_empty++;
                    if (want.header_error) n_hdr_err++;
                    if (got.out_byte !== want.out_byte
                            || got.last_of_packet !== want.last_of_packet
                            || got.empty_packet !== want.empty_packet
                            || got.header_error !== want.header_error
                            || got.stream_tag !== want.stream_tag)
                        note_failure($sformatf(
                            "mismatch byte/last/empty/err/tag exp %02h/%b/%b/%b/%04h got %02h/%b/%b/%b/%04h",
                            want.out_byte, want.last_of_packet, want.empty_packet,
                            want.header_error, want.stream_tag,
                            got.out_byte, got.last_of_packet, got.empty_packet,
                            got.header_error, got.stream_tag));
                end
            end
            m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("hex_length_prefixed_deframer regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        logic [TAG_W-1:0] phase_tags [6];
        logic [LEN_W-1:0] len;
        int               budget;
        int               sel;

        phase_tags = '{16'hFFFF, 16'h0000, 16'($urandom), 16'h8001,
                       16'($urandom), 16'($urandom)};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset value of the stream identifier
        foreach (directed_bytes[k]) framed_q.push_back(directed_bytes[k]);
        wait_drained();

        // Random phases, each under its own stream identifier; one phase runs without gaps
        for (int p = 0; p < 6; p++) begin
            write_stream_id(phase_tags[p]);
            calm = (p == 2);
            budget = 0;
            while (budget < 210) begin
                sel = $urandom_range(99);
                if (sel < 12) begin
                    len = LEN_W'($urandom_range(65535));
                    budget += queue_frame(len, 1'b1);
                end else begin
                    if (sel < 22) len = '0;
                    else if (sel < 96) len = LEN_W'($urandom_range(16, 1));
                    else len = LEN_W'($urandom_range(300, 17));
                    budget += queue_frame(len, 1'b0);
                end
            end
            wait_drained();
        end
        calm = 1'b0;

        $display("Covered %0d stream bytes and %0d packet results under %0d stream ids,",
                 n_driven, n_checked, n_tags);
        $display("including %0d empty packets, %0d of them with a header error.",
                 n_empty, n_hdr_err);
        if (n_fail == 0) begin
            $display("hex_length_prefixed_deframer regression: pass");
        end else begin
            $display("%0d mismatches", n_fail);
            $display("hex_length_prefixed_deframer regression: fail");
        end
        $finish;
    end

endmodule
